FILE: rtl/core/mkpq_pkg.sv
// Shared types, constants and codes for the minimum-key priority queue.
package mkpq_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int TAG_BITS_DEF = 16;

    localparam int IN_TAG_W  = 16;
    localparam int PRIO_W    = 12;
    localparam int TREAT_W   = 10;
    localparam int STATUS_W  = 2;
    localparam int HELD_W    = 5;
    localparam int KEY_W     = 22;
    localparam int KEY_SCALE = 1000;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

    typedef struct packed {
        logic                mode;
        logic [IN_TAG_W-1:0] entry_tag;
        logic [PRIO_W-1:0]   wait_priority;
        logic [TREAT_W-1:0]  treat_time;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IN_TAG_W-1:0] out_tag;
        logic [PRIO_W-1:0]   out_priority;
        logic [TREAT_W-1:0]  out_treat;
        logic [HELD_W-1:0]   held_count;
    } out_beat_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } scan_ctl_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_SHIFT,
        S_RESULT
    } state_t;

endpackage

FILE: rtl/core/mkpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mkpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/mkpq_key_unit.sv
// Key unit: forms priority*1000+treatment and keeps the running minimum.
module mkpq_key_unit #(
    parameter int REC_W = 38,
    parameter int AW    = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mkpq_pkg::scan_ctl_t    ctl,
    input  logic [REC_W-1:0]       rec,
    input  logic [AW-1:0]          idx,
    output logic [REC_W-1:0]       best_rec,
    output logic [AW-1:0]          best_idx,
    output logic                   busy
);
    import mkpq_pkg::*;

    logic [KEY_W-1:0] key_next;
    logic [KEY_W-1:0] key_reg;
    logic [REC_W-1:0] rec_reg;
    logic [AW-1:0]    idx_reg;
    logic             key_vld_reg;
    logic [KEY_W-1:0] best_key_reg;
    logic [REC_W-1:0] best_rec_reg;
    logic [AW-1:0]    best_idx_reg;
    logic             have_best_reg;
    logic             take;

    assign key_next = KEY_W'(rec[PRIO_W+TREAT_W-1:TREAT_W]) * KEY_W'(KEY_SCALE)
                    + KEY_W'(rec[TREAT_W-1:0]);

    // strict less keeps the earliest entry on equal keys
    assign take = key_vld_reg && (!have_best_reg || (key_reg < best_key_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_vld_reg   <= 1'b0;
            have_best_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            key_vld_reg   <= 1'b0;
            have_best_reg <= 1'b0;
        end
        else
        begin
            key_vld_reg <= ctl.sample;
            if (take)
            begin
                have_best_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sample)
        begin
            key_reg <= key_next;
            rec_reg <= rec;
            idx_reg <= idx;
        end
        if (take)
        begin
            best_key_reg <= key_reg;
            best_rec_reg <= rec_reg;
            best_idx_reg <= idx_reg;
        end
    end

    assign best_rec = best_rec_reg;
    assign best_idx = best_idx_reg;
    assign busy     = key_vld_reg;

endmodule

FILE: rtl/core/min_key_priority_queue.sv
// Top level: bounded minimum-key priority queue with linear-scan pop.
// Push: the store is written in the accept cycle, then the result state loads the result once the output is free.
// Pop: the single RAM read port first scans every held entry for the minimum and then
// closes the gap by moving each later entry down one place.
// One item at a time; the next item is taken while a result still waits at the output.
// Reset (rst_n, asynchronous, active low) empties the queue; entry storage is not cleared.
module min_key_priority_queue #(
    parameter int DEPTH    = mkpq_pkg::DEPTH_DEF,
    parameter int TAG_BITS = mkpq_pkg::TAG_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mkpq_pkg::in_beat_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output mkpq_pkg::out_beat_t out_data
);
    import mkpq_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int REC_W = TAG_BITS + PRIO_W + TREAT_W;

    state_t               state_reg, state_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [CW-1:0]        scan_idx_reg, scan_idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [AW-1:0]        rd_idx_reg, rd_idx_next;
    logic [CW-1:0]        sh_idx_reg, sh_idx_next;
    logic                 sh_pend_reg, sh_pend_next;
    logic [AW-1:0]        sh_waddr_reg, sh_waddr_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic                 res_pop_reg, res_pop_next;
    logic                 out_valid_reg, out_valid_next;
    out_beat_t            out_data_reg, out_data_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [REC_W-1:0]     ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [REC_W-1:0]     ram_rdata;

    scan_ctl_t            scan_ctl;
    logic [REC_W-1:0]     best_rec;
    logic [AW-1:0]        best_idx;
    logic                 key_busy;
    logic                 out_free;
    logic                 sh_more;

    mkpq_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mkpq_key_unit #(
        .REC_W (REC_W),
        .AW    (AW)
    ) u_key (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (scan_ctl),
        .rec      (ram_rdata),
        .idx      (rd_idx_reg),
        .best_rec (best_rec),
        .best_idx (best_idx),
        .busy     (key_busy)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign sh_more  = sh_idx_reg < cnt_reg;
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_data.mode == MODE_POP && cnt_reg != '0)
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_RESULT;
                    end
                end
            end
            S_SCAN:
            begin
                if ((scan_idx_reg + CW'(1)) == cnt_reg)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !key_busy)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (!sh_more && !sh_pend_reg)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next        = cnt_reg;
        scan_idx_next   = scan_idx_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        sh_idx_next     = sh_idx_reg;
        sh_pend_next    = 1'b0;
        sh_waddr_next   = sh_waddr_reg;
        res_status_next = res_status_reg;
        res_pop_next    = res_pop_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        scan_ctl.clear  = 1'b0;
        scan_ctl.sample = rd_vld_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    res_pop_next = 1'b0;
                    if (in_data.mode == MODE_PUSH)
                    begin
                        if (cnt_reg < CW'(DEPTH))
                        begin
                            ram_we          = 1'b1;
                            ram_waddr       = cnt_reg[AW-1:0];
                            ram_wdata       = {TAG_BITS'(in_data.entry_tag),
                                               in_data.wait_priority, in_data.treat_time};
                            cnt_next        = cnt_reg + CW'(1);
                            res_status_next = STAT_OK;
                        end
                        else
                        begin
                            res_status_next = STAT_FULL;
                        end
                    end
                    else if (cnt_reg == '0)
                    begin
                        res_status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        res_status_next = STAT_OK;
                        res_pop_next    = 1'b1;
                        scan_ctl.clear  = 1'b1;
                        scan_idx_next   = '0;
                    end
                end
            end
            S_SCAN:
            begin
                ram_raddr     = scan_idx_reg[AW-1:0];
                rd_vld_next   = 1'b1;
                rd_idx_next   = scan_idx_reg[AW-1:0];
                scan_idx_next = scan_idx_reg + CW'(1);
            end
            S_DRAIN:
            begin
                if (!rd_vld_reg && !key_busy)
                begin
                    sh_idx_next = CW'(best_idx) + CW'(1);
                end
            end
            S_SHIFT:
            begin
                if (sh_more)
                begin
                    ram_raddr     = sh_idx_reg[AW-1:0];
                    sh_pend_next  = 1'b1;
                    sh_waddr_next = sh_idx_reg[AW-1:0] - AW'(1);
                    sh_idx_next   = sh_idx_reg + CW'(1);
                end
                if (sh_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = sh_waddr_reg;
                    ram_wdata = ram_rdata;
                end
                if (!sh_more && !sh_pend_reg)
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.status = res_status_reg;
                    out_data_next.held_count = HELD_W'(cnt_reg);
                    if (res_pop_reg)
                    begin
                        out_data_next.out_tag =
                            IN_TAG_W'(best_rec[REC_W-1:PRIO_W+TREAT_W]);
                        out_data_next.out_priority = best_rec[PRIO_W+TREAT_W-1:TREAT_W];
                        out_data_next.out_treat    = best_rec[TREAT_W-1:0];
                    end
                    else
                    begin
                        out_data_next.out_tag      = '0;
                        out_data_next.out_priority = '0;
                        out_data_next.out_treat    = '0;
                    end
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            sh_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            sh_pend_reg   <= sh_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        sh_idx_reg     <= sh_idx_next;
        sh_waddr_reg   <= sh_waddr_next;
        res_status_reg <= res_status_next;
        res_pop_reg    <= res_pop_next;
        out_data_reg   <= out_data_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("held count beyond store depth");

    a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE || state_reg == S_SHIFT))
        else $error("store written outside push or compaction");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.mode == MODE_PUSH && cnt_reg < CW'(DEPTH))
        |=> cnt_reg == $past(cnt_reg) + CW'(1))
        else $error("accepted push did not advance the count");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN || state_reg == S_SHIFT) |-> cnt_reg != '0)
        else $error("scan or compaction on an empty store");

endmodule

FILE: tb/tb_min_key_priority_queue.sv
// Self-checking testbench for min_key_priority_queue: push/pop traffic checked against a scan model.
`timescale 1ns / 1ps

module tb_min_key_priority_queue;
    import mkpq_pkg::*;

    localparam int DEPTH          = DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 1230;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_START     = 1500;
    localparam int HOLD_LEN       = 400;
    localparam int RX_CALM_START  = 2200;
    localparam int RX_CALM_END    = 2700;
    localparam int TX_CALM_START  = 500;
    localparam int TX_CALM_END    = 700;
    localparam int TAIL_CYCLES    = 60;

    typedef struct packed {
        logic [IN_TAG_W-1:0] tag;
        logic [PRIO_W-1:0]   prio;
        logic [TREAT_W-1:0]  treat;
    } entry_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_beat_t  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_beat_t out_data;

    in_beat_t  pending_items[$];
    out_beat_t due_results[$];
    entry_t    held_entries[$];
    logic      in_taken   = 1'b0;
    int        sent       = 0;
    int        rx_cycle   = 0;
    int        idle_run   = 0;
    int        errors     = 0;

    min_key_priority_queue uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #2 clk = ~clk;

    function automatic int entry_key(entry_t e);
        return int'(e.prio) * KEY_SCALE + int'(e.treat);
    endfunction

    function automatic out_beat_t serve_item(in_beat_t b);
        out_beat_t r;
        entry_t    e;
        int        best;
        r = '0;
        r.status = STAT_OK;
        if (b.mode == MODE_PUSH)
        begin
            if (held_entries.size() >= DEPTH)
            begin
                r.status = STAT_FULL;
            end
            else
            begin
                e.tag   = b.entry_tag;
                e.prio  = b.wait_priority;
                e.treat = b.treat_time;
                held_entries.push_back(e);
            end
        end
        else if (held_entries.size() == 0)
        begin
            r.status = STAT_EMPTY;
        end
        else
        begin
            best = 0;
            for (int i = 1; i < held_entries.size(); i++)
            begin
                if (entry_key(held_entries[i]) < entry_key(held_entries[best]))
                    best = i;
            end
            r.out_tag      = held_entries[best].tag;
            r.out_priority = held_entries[best].prio;
            r.out_treat    = held_entries[best].treat;
            held_entries.delete(best);
        end
        r.held_count = HELD_W'(held_entries.size());
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic add_item(logic mode, int tag, int prio, int treat);
        in_beat_t b;
        b.mode          = mode;
        b.entry_tag     = IN_TAG_W'(tag);
        b.wait_priority = PRIO_W'(prio);
        b.treat_time    = TREAT_W'(treat);
        pending_items.push_back(b);
    endtask

    always @(posedge clk)
    begin
        out_beat_t want;
        if (out_valid && out_ready)
        begin
            if (due_results.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d held %0d",
                       out_data.status, out_data.held_count);
                errors++;
            end
            else
            begin
                want = due_results.pop_front();
                check_field("status", want.status, out_data.status);
                check_field("out_tag", want.out_tag, out_data.out_tag);
                check_field("out_priority", want.out_priority, out_data.out_priority);
                check_field("out_treat", want.out_treat, out_data.out_treat);
                check_field("held_count", want.held_count, out_data.held_count);
            end
        end
        if (in_valid && in_ready)
            due_results.push_back(serve_item(in_data));
        in_taken <= in_valid && in_ready;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
    end

    always @(negedge clk)
    begin
        logic go;
        if (rst_n && (!in_valid || in_taken))
        begin
            go = pending_items.size() > 0 &&
                 ((sent >= TX_CALM_START && sent < TX_CALM_END) || $urandom_range(99) >= 8);
            if (go)
            begin
                in_data <= pending_items.pop_front();
                sent    <= sent + 1;
            end
            in_valid <= go;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                out_ready <= 1'b0;
            else if (rx_cycle >= RX_CALM_START && rx_cycle < RX_CALM_END)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(99) >= 8);
        end
    end

    initial
    begin
        wait (idle_run >= WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int  push_pct;
        logic mode;
        int  prio;
        int  treat;

        // empty pop, extremes, ties and treatment past the priority step
        add_item(MODE_POP, 16'h1234, 7, 7);
        add_item(MODE_PUSH, 16'hFFFF, 4095, 1023);
        add_item(MODE_PUSH, 16'h0000, 0, 0);
        add_item(MODE_POP, 0, 0, 0);
        add_item(MODE_PUSH, 16'h0001, 1, 1000);
        add_item(MODE_PUSH, 16'h0002, 2, 0);
        add_item(MODE_PUSH, 16'h0003, 1, 1001);
        add_item(MODE_POP, 16'hFFFF, 4095, 1023);
        add_item(MODE_POP, 0, 0, 0);
        for (int i = 0; i < DEPTH - 2; i++)
            add_item(MODE_PUSH, (i % 2) ? 16'hAAAA + i : 16'h5555 + i, i % 3,
                     (i % 4 == 1) ? 999 : 0);
        add_item(MODE_PUSH, 16'hBEEF, 0, 0);
        add_item(MODE_POP, 0, 0, 0);

        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
            begin
                case ($urandom_range(3))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    2: push_pct = 85;
                    default: push_pct = 97;
                endcase
            end
            mode = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
            if ($urandom_range(1))
            begin
                prio = $urandom_range(3);
                case ($urandom_range(4))
                    0: treat = 0;
                    1: treat = 999;
                    2: treat = 1000 + $urandom_range(23);
                    default: treat = $urandom_range(3);
                endcase
            end
            else
            begin
                prio  = $urandom_range(4095);
                treat = $urandom_range(1023);
            end
            add_item(mode, $urandom_range(16'hFFFF), prio, treat);
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_items.size() == 0);
        @(posedge clk);
        while (in_valid || due_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
